FILE: sv/pfsb_pkg.sv
`timescale 1ns / 1ps

package pfsb_pkg;

	// default screen geometry
	localparam int unsigned SCREEN_WIDTH_DEF  = 128;
	localparam int unsigned SCREEN_HEIGHT_DEF = 64;

	// configuration port geometry
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	// depth of the queues between and behind the two halves
	localparam int unsigned CMD_DEPTH = 2;
	localparam int unsigned OUT_DEPTH = 4;

	// signed width of screen coordinates, wide enough to never wrap
	localparam int unsigned COORD_W = 18;

	// request kinds
	localparam logic REQ_DATA = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// register indexes on the configuration port
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SPRITE_X      = 3'd0,
		REG_SPRITE_Y      = 3'd1,
		REG_SPRITE_WIDTH  = 3'd2,
		REG_SPRITE_HEIGHT = 3'd3,
		REG_DRAW_MODE     = 3'd4
	} reg_index_t;

	// draw modes
	typedef enum logic [1:0] {
		MODE_OVERWRITE = 2'd0,
		MODE_OR        = 2'd1,
		MODE_MASK      = 2'd2,
		MODE_ERASE     = 2'd3
	} draw_mode_t;

	// input transaction
	typedef struct packed {
		logic       req_type;
		logic [7:0] image_byte;
		logic [7:0] mask_byte;
		logic [9:0] read_address;
	} in_t;

	// result transaction
	typedef struct packed {
		logic [7:0] read_data;
		logic       sprite_done;
	} out_t;

	// classified command handed from the front to the back
	typedef struct packed {
		logic                      is_read;
		logic [9:0]                read_address;
		logic                      done;
		logic [7:0]                we;
		logic [7:0]                val;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] top;
	} cmd_t;

endpackage

FILE: sv/pfsb_queue.sv
`timescale 1ns / 1ps

module pfsb_queue #(
	parameter type         T     = logic,
	parameter int unsigned DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  T                             wdata,
	output logic                         full,
	input  logic                         pop,
	output T                             rdata,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	T              slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = slots_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// storage slots
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: sv/pfsb_front.sv
`timescale 1ns / 1ps

module pfsb_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr,
	input  logic [pfsb_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [pfsb_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               accept,
	input  pfsb_pkg::in_t                      item,
	output pfsb_pkg::cmd_t                     cmd
);

	import pfsb_pkg::*;

	logic signed [15:0] sprite_x_q;
	logic signed [15:0] sprite_y_q;
	logic [7:0]         width_q;
	logic [7:0]         height_q;
	draw_mode_t         mode_q;
	logic [7:0]         column_q;
	logic [4:0]         page_q;

	logic [5:0]         pages;
	logic [7:0]         row_base;
	logic               in_bounds;
	logic               col_wrap;
	logic               page_wrap;
	logic               is_read;
	logic [7:0]         row_ok;
	logic [7:0]         we_raw;
	logic [7:0]         val_raw;
	logic               done;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sprite_x_q <= '0;
			sprite_y_q <= '0;
			width_q    <= '0;
			height_q   <= '0;
			mode_q     <= MODE_OVERWRITE;
		end else if (cfg_wr) begin
			unique case (reg_index_t'(cfg_index))
				REG_SPRITE_X:      sprite_x_q <= $signed(cfg_data);
				REG_SPRITE_Y:      sprite_y_q <= $signed(cfg_data);
				REG_SPRITE_WIDTH:  width_q    <= cfg_data[7:0];
				REG_SPRITE_HEIGHT: height_q   <= cfg_data[7:0];
				REG_DRAW_MODE:     mode_q     <= draw_mode_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	// sprite geometry and counter position
	assign pages     = 6'((9'(height_q) + 9'd7) >> 3);
	assign row_base  = {page_q, 3'b000};
	assign in_bounds = (column_q < width_q) && (6'(page_q) < pages);
	assign col_wrap  = (9'(column_q) + 9'd1) >= 9'(width_q);
	assign page_wrap = (6'(page_q) + 6'd1) >= pages;
	assign is_read   = (item.req_type == REQ_READ);
	assign done      = !in_bounds || (col_wrap && page_wrap);

	// rows that still lie inside the sprite height
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			row_ok[b] = (row_base + 8'(b)) < height_q;
		end
	end

	// per-bit write enable and value for the draw mode
	always_comb begin
		case (mode_q)
			MODE_OVERWRITE: begin
				we_raw  = 8'hff;
				val_raw = item.image_byte;
			end
			MODE_OR: begin
				we_raw  = item.image_byte;
				val_raw = 8'hff;
			end
			MODE_MASK: begin
				we_raw  = item.mask_byte;
				val_raw = item.image_byte;
			end
			default: begin
				we_raw  = item.image_byte;
				val_raw = 8'h00;
			end
		endcase
	end

	// command for the back end
	always_comb begin
		cmd.is_read      = is_read;
		cmd.read_address = item.read_address;
		cmd.done         = !is_read && done;
		cmd.we           = (!is_read && in_bounds) ? (we_raw & row_ok) : 8'h00;
		cmd.val          = val_raw;
		cmd.px           = COORD_W'(sprite_x_q) + COORD_W'($signed({1'b0, column_q}));
		cmd.top          = COORD_W'(sprite_y_q) + COORD_W'($signed({1'b0, row_base}));
	end

	// column and page counters advance on each data transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			page_q   <= '0;
		end else if (accept && !is_read) begin
			if (!in_bounds) begin
				column_q <= '0;
				page_q   <= '0;
			end else if (col_wrap) begin
				column_q <= '0;
				page_q   <= page_wrap ? 5'd0 : page_q + 5'd1;
			end else begin
				column_q <= column_q + 8'd1;
			end
		end
	end

endmodule

FILE: sv/pfsb_back.sv
`timescale 1ns / 1ps

module pfsb_back #(
	parameter int unsigned SCREEN_WIDTH  = pfsb_pkg::SCREEN_WIDTH_DEF,
	parameter int unsigned SCREEN_HEIGHT = pfsb_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_empty,
	input  pfsb_pkg::cmd_t  cmd,
	output logic            cmd_pop,
	output logic            clearing,
	output logic            empty,
	input  logic            pop,
	output pfsb_pkg::out_t  result
);

	import pfsb_pkg::*;

	localparam int unsigned PAGES       = (SCREEN_HEIGHT + 7) / 8;
	localparam int unsigned STORE_BYTES = SCREEN_WIDTH * PAGES;
	localparam int unsigned AW          = $clog2(STORE_BYTES);
	localparam int unsigned LAST_ROWS   = SCREEN_HEIGHT - (PAGES - 1) * 8;
	localparam logic [7:0]  LAST_MASK   = 8'((1 << LAST_ROWS) - 1);
	localparam int unsigned OCW         = $clog2(OUT_DEPTH + 1);

	// clearing sweep
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	// issue stage
	logic                      op_idx_q;
	logic                      last_op;
	logic                      credit;
	logic                      issue;
	logic signed [COORD_W-1:0] pg;
	logic [15:0]               we16;
	logic [15:0]               val16;
	logic [7:0]                byte_we;
	logic [7:0]                byte_val;
	logic                      pos_ok;
	logic [31:0]               draw_addr;
	logic [AW-1:0]             addr_s1;
	logic                      rd_zero_s1;

	// access stage
	logic          v_s2;
	logic [AW-1:0] addr_s2;
	logic [7:0]    we_s2;
	logic [7:0]    val_s2;
	logic          is_read_s2;
	logic          zero_s2;
	logic          last_s2;
	logic          done_s2;
	logic [7:0]    rdata_s2;
	logic [7:0]    cur_byte;
	logic [7:0]    new_byte;

	// last write, for the back-to-back read of the same byte
	logic          fwd_v_q;
	logic [AW-1:0] fwd_addr_q;
	logic [7:0]    fwd_data_q;

	// store write port
	logic          op_wr;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [7:0]    mem [STORE_BYTES];

	// result queue
	logic          res_push;
	logic          res_full;
	out_t          res_data;
	logic [OCW-1:0] res_count;

	assign clearing = clr_q;

	// sweep zeroes through the store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(STORE_BYTES - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// target page and bit lanes of this op
	always_comb begin
		pg       = (cmd.top >>> 3) + $signed({{(COORD_W-1){1'b0}}, op_idx_q});
		we16     = {8'h00, cmd.we} << cmd.top[2:0];
		val16    = {8'h00, cmd.val} << cmd.top[2:0];
		byte_we  = op_idx_q ? we16[15:8] : we16[7:0];
		byte_val = op_idx_q ? val16[15:8] : val16[7:0];
		pos_ok   = (pg >= 0) && (pg < $signed(COORD_W'(PAGES)))
			&& (cmd.px >= 0) && (cmd.px < $signed(COORD_W'(SCREEN_WIDTH)));
		if (pg == $signed(COORD_W'(PAGES - 1))) begin
			byte_we = byte_we & LAST_MASK;
		end
		if (!pos_ok) begin
			byte_we = 8'h00;
		end
		draw_addr  = 32'(pg[COORD_W-2:0]) * 32'(SCREEN_WIDTH)
			+ 32'(cmd.px[COORD_W-2:0]);
		rd_zero_s1 = 32'(cmd.read_address) >= 32'(STORE_BYTES);
		addr_s1    = cmd.is_read ? AW'(cmd.read_address) : AW'(draw_addr);
	end

	// issue control: a data command takes two ops, a read one
	assign last_op = cmd.is_read || op_idx_q;
	assign credit  = (32'(res_count) + 32'(v_s2 && last_s2)) < 32'(OUT_DEPTH);
	assign issue   = !clr_q && !cmd_empty && (!last_op || credit);
	assign cmd_pop = issue && last_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_idx_q <= 1'b0;
			v_s2     <= 1'b0;
			fwd_v_q  <= 1'b0;
		end else begin
			if (issue) begin
				op_idx_q <= !last_op;
			end
			v_s2    <= issue;
			fwd_v_q <= op_wr;
		end
	end

	// access stage payload
	always_ff @(posedge clk) begin
		if (issue) begin
			addr_s2    <= addr_s1;
			we_s2      <= cmd.is_read ? 8'h00 : byte_we;
			val_s2     <= byte_val;
			is_read_s2 <= cmd.is_read;
			zero_s2    <= rd_zero_s1;
			last_s2    <= last_op;
			done_s2    <= cmd.done;
		end
		if (op_wr) begin
			fwd_addr_q <= addr_s2;
			fwd_data_q <= new_byte;
		end
	end

	// merge the new bits into the byte
	assign cur_byte = (fwd_v_q && (fwd_addr_q == addr_s2)) ? fwd_data_q : rdata_s2;
	assign new_byte = (cur_byte & ~we_s2) | (val_s2 & we_s2);
	assign op_wr    = v_s2 && !is_read_s2 && (we_s2 != 8'h00);

	// write port shared by the sweep and the ops
	assign mem_we    = clr_q || op_wr;
	assign mem_waddr = clr_q ? clr_addr_q : addr_s2;
	assign mem_wdata = clr_q ? 8'h00 : new_byte;

	// frame store: one read and one write port
	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s2 <= mem[addr_s1];
		end
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	// result of the last op of each command
	assign res_push           = v_s2 && last_s2;
	assign res_data.read_data = (is_read_s2 && !zero_s2) ? cur_byte : 8'h00;
	assign res_data.sprite_done = done_s2;

	pfsb_queue #(
		.T     (out_t),
		.DEPTH (OUT_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_data),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty),
		.count  (res_count)
	);

	// credit check keeps the result queue from overflowing
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result queue overflow");

	// no op runs while the store is being swept
	a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !issue && !op_wr)
		else $error("op issued during clearing sweep");

	// second op of a data command finds its command still at the head
	a_second_op_held: assert property (@(posedge clk) disable iff (!arst_n)
		op_idx_q |-> !cmd_empty && !cmd.is_read)
		else $error("second op lost its command");

	// a forwarded byte always comes from the op just before
	a_fwd_follows_write: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_v_q |-> $past(v_s2))
		else $error("forward without preceding write");

endmodule

FILE: sv/page_framebuffer_sprite_blitter_top.sv
`timescale 1ns / 1ps

// channel   | handshake          | payload
// ----------+--------------------+-----------------------------------------
// input     | push / full        | item   (req_type, image_byte, mask_byte,
//           |                    |         read_address)
// result    | empty / pop        | result (read_data, sprite_done)
// config    | cfg_wr             | cfg_index, cfg_data
//
// In the back end a data transaction makes one store access per framebuffer
// page it can touch, through the store's single write port; a read makes a
// single access. A result passes through the command queue, the access stage
// and the result queue before it shows on the result ports.
// After reset all SCREEN_WIDTH*((SCREEN_HEIGHT+7)/8) bytes of the store are swept
// to zero (1024 at the defaults); full stays high meanwhile, config writes work.
// The front and back are decoupled by a 2-entry command queue and results wait
// in a 4-entry queue; a stall on one side blocks the other once these queues fill.

module page_framebuffer_sprite_blitter_top #(
	parameter int unsigned SCREEN_WIDTH  = pfsb_pkg::SCREEN_WIDTH_DEF,
	parameter int unsigned SCREEN_HEIGHT = pfsb_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  pfsb_pkg::in_t                      item,
	output logic                               full,
	input  logic                               pop,
	output pfsb_pkg::out_t                     result,
	output logic                               empty,
	input  logic                               cfg_wr,
	input  logic [pfsb_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [pfsb_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import pfsb_pkg::*;

	logic accept;
	cmd_t cmd_in;
	cmd_t cmd_head;
	logic cmd_full;
	logic cmd_empty;
	logic cmd_pop;
	logic clearing;

	// input transaction taken when the command queue has room and the clearing sweep is done
	assign full   = cmd_full || clearing;
	assign accept = push && !full;

	pfsb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (item),
		.cmd       (cmd_in)
	);

	pfsb_queue #(
		.T     (cmd_t),
		.DEPTH (CMD_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty),
		.count  ()
	);

	pfsb_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.clearing  (clearing),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
